/* src/weighted_pick_with_retirement_assert.svh */
// Assertion macros for the weighted pick block.
// Included by wpr_ctrl to check its own control logic; no other dependencies.
`ifndef WEIGHTED_PICK_WITH_RETIREMENT_ASSERT_SVH
`define WEIGHTED_PICK_WITH_RETIREMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/wpr_pkg.sv */
// Package for the weighted pick block: sizes, command and state codes, and the
// structs passed between controller, entry memory and top level. No dependencies.
`timescale 1ns / 1ps

package wpr_pkg;

	localparam int ENTRIES     = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int IDX_W       = $clog2(ENTRIES);
	// running sums of up to ENTRIES weights
	localparam int TOT_W       = WEIGHT_BITS + IDX_W;
	// scan counter also holds ENTRIES itself
	localparam int CNT_W       = IDX_W + 1;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_PICK = 2'd1,
		CMD_TAKE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAKE,
		ST_SUM,
		ST_SCALE,
		ST_MUL,
		ST_SRCH,
		ST_RESP
	} state_t;

	// one row of the entry memory
	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [7:0]             limit;
		logic [7:0]             count;
	} entry_t;

	// memory access from the controller
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// unpacked request fields
	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  idx;
		logic [15:0] weight;
		logic [7:0]  limit;
		logic [31:0] rnd;
	} req_t;

	// response fields
	typedef struct packed {
		logic [3:0] chosen;
		logic       none;
		logic [7:0] count;
		logic       retired;
	} res_t;

endpackage

/* src/wpr_table.sv */
// Entry memory: one write port and one read port with registered read data.
// Depends on wpr_pkg for the row layout and depth.
`timescale 1ns / 1ps

module wpr_table (
	input  logic             clk,
	input  wpr_pkg::mem_req_t mem_req,
	output wpr_pkg::entry_t  rdata
);
	import wpr_pkg::*;

	entry_t mem [ENTRIES];
	entry_t rdata_q;

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rdata_q <= mem[mem_req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/wpr_scale.sv */
// Threshold unit: registered product of the random fraction and the total weight,
// keeping the upper bits. Depends on wpr_pkg for the total width.
`timescale 1ns / 1ps

module wpr_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               rnd,
	input  logic [wpr_pkg::TOT_W-1:0] total,
	output logic [wpr_pkg::TOT_W-1:0] thr,
	output logic                      done
);
	import wpr_pkg::*;

	localparam int PROD_W = 32 + TOT_W;

	logic [PROD_W-1:0] prod;
	logic [TOT_W-1:0]  thr_q;
	logic              done_q;

	// threshold = (rnd * total) >> 32
	assign prod = PROD_W'(rnd) * PROD_W'(total);

	always_ff @(posedge clk) begin
		if (start) begin
			thr_q <= prod[PROD_W-1:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	assign thr  = thr_q;
	assign done = done_q;

endmodule

/* src/wpr_ctrl.sv */
// Sequencer for load, pick and take: read-modify-write on the entry memory,
// two scan passes for pick, active mask flops. Depends on wpr_pkg and the assert header.
`timescale 1ns / 1ps
`include "weighted_pick_with_retirement_assert.svh"

module wpr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  wpr_pkg::req_t             req,
	output logic                      res_valid,
	input  logic                      res_ready,
	output wpr_pkg::res_t             res,
	output wpr_pkg::mem_req_t         mem_req,
	input  wpr_pkg::entry_t           mem_rdata,
	output logic                      scale_start,
	output logic [31:0]               scale_rnd,
	output logic [wpr_pkg::TOT_W-1:0] scale_total,
	input  logic [wpr_pkg::TOT_W-1:0] scale_thr,
	input  logic                      scale_done
);
	import wpr_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [TOT_W-1:0] acc_q, acc_d;
	logic [TOT_W-1:0] total_q, total_d;
	logic [ENTRIES-1:0] active_q, active_d;
	res_t             res_q, res_d;
	logic [31:0]      rnd_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             issue;
	logic             idx_ok;
	logic [IDX_W-1:0] req_addr;
	logic [TOT_W-1:0] rd_w;
	logic [TOT_W-1:0] acc_sum;
	logic             rd_last;
	logic [7:0]       inc_cnt;
	logic             hit_lim;

	assign idx_ok   = 32'(req.idx) < 32'(ENTRIES);
	assign req_addr = IDX_W'(req.idx);

	// weight of the entry whose read data arrives now, zero if inactive
	assign rd_w    = active_q[rd_idx_s1] ? TOT_W'(mem_rdata.weight) : '0;
	assign acc_sum = acc_q + rd_w;
	assign rd_last = rd_idx_s1 == IDX_W'(ENTRIES - 1);

	// take: saturating count and retire check
	assign inc_cnt = (mem_rdata.count == 8'hFF) ? 8'hFF : mem_rdata.count + 8'd1;
	assign hit_lim = inc_cnt >= mem_rdata.limit;

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		acc_d       = acc_q;
		total_d     = total_q;
		active_d    = active_q;
		res_d       = res_q;
		mem_req     = '0;
		issue       = 1'b0;
		scale_start = 1'b0;
		req_ready   = 1'b0;
		res_valid   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					res_d   = '0;
					state_d = ST_RESP;
					case (cmd_t'(req.cmd))
						CMD_LOAD: begin
							if (idx_ok) begin
								mem_req.we           = 1'b1;
								mem_req.waddr        = req_addr;
								mem_req.wdata.weight = WEIGHT_BITS'(req.weight);
								mem_req.wdata.limit  = req.limit;
								mem_req.wdata.count  = 8'd0;
								active_d[req_addr]   = 1'b1;
							end
						end
						CMD_PICK: begin
							cnt_d   = '0;
							acc_d   = '0;
							state_d = ST_SUM;
						end
						CMD_TAKE: begin
							if (idx_ok) begin
								mem_req.re    = 1'b1;
								mem_req.raddr = req_addr;
								state_d       = ST_TAKE;
							end
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end

			// read data of the addressed entry is here: write back the count
			ST_TAKE: begin
				mem_req.we          = 1'b1;
				mem_req.waddr       = idx_q;
				mem_req.wdata       = mem_rdata;
				mem_req.wdata.count = inc_cnt;
				if (hit_lim) begin
					active_d[idx_q] = 1'b0;
				end
				res_d.count   = inc_cnt;
				res_d.retired = hit_lim || !active_q[idx_q];
				state_d       = ST_RESP;
			end

			// first pass: total active weight
			ST_SUM: begin
				if (cnt_q < CNT_W'(ENTRIES)) begin
					issue         = 1'b1;
					mem_req.re    = 1'b1;
					mem_req.raddr = cnt_q[IDX_W-1:0];
					cnt_d         = cnt_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					acc_d = acc_sum;
					if (rd_last) begin
						total_d = acc_sum;
						state_d = ST_SCALE;
					end
				end
			end

			ST_SCALE: begin
				cnt_d = '0;
				acc_d = '0;
				if (total_q == '0) begin
					res_d.none = 1'b1;
					state_d    = ST_RESP;
				end else begin
					scale_start = 1'b1;
					state_d     = ST_MUL;
				end
			end

			ST_MUL: begin
				if (scale_done) begin
					state_d = ST_SRCH;
				end
			end

			// second pass: first running sum above the threshold
			ST_SRCH: begin
				if (cnt_q < CNT_W'(ENTRIES)) begin
					issue         = 1'b1;
					mem_req.re    = 1'b1;
					mem_req.raddr = cnt_q[IDX_W-1:0];
					cnt_d         = cnt_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					acc_d = acc_sum;
					if (acc_sum > scale_thr) begin
						res_d.chosen = 4'(rd_idx_s1);
						state_d      = ST_RESP;
					end else if (rd_last) begin
						state_d = ST_RESP;
					end
				end
			end

			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= '0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q   <= state_d;
			active_q  <= active_d;
			rd_vld_s1 <= issue;
			cnt_q     <= cnt_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		acc_q     <= acc_d;
		total_q   <= total_d;
		res_q     <= res_d;
		rd_idx_s1 <= mem_req.raddr;
		if (req_valid && req_ready) begin
			rnd_q <= req.rnd;
			idx_q <= req_addr;
		end
	end

	assign res         = res_q;
	assign scale_rnd   = rnd_q;
	assign scale_total = total_q;

	`WPR_ASSERT_IMP(a_no_rw_clash, clk, arst_n, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "write and read hit the same entry")
	`WPR_ASSERT_IMP(a_thr_below_total, clk, arst_n, scale_done, scale_thr < total_q, "threshold not below total weight")
	`WPR_ASSERT_NXT(a_take_rmw, clk, arst_n, req_valid && req_ready && req.cmd == CMD_TAKE && idx_ok, state_q == ST_TAKE, "take did not enter write-back")
	`WPR_ASSERT_IMP(a_none_clean, clk, arst_n, res_valid && res.none, res.chosen == 4'd0 && res.count == 8'd0, "none response carries data")

endmodule

/* src/weighted_pick_with_retirement.sv */
// Top level of the weighted pick block: stream ports, field packing, output register.
// Depends on wpr_pkg, wpr_ctrl, wpr_table and wpr_scale.
`timescale 1ns / 1ps

// Weighted random pick over a table of ENTRIES entries, with use counting and
// retirement. One request at a time: s_tready is high only while the sequencer
// is idle, and a finished response waits in the output register so the next
// request can be taken meanwhile. Take reads the entry, then writes back the
// count. Pick scans the entry memory twice through its single read port, one
// weight per cycle (total, then the prefix search, which stops at the chosen
// entry), plus the threshold multiply. No clearing pass is needed after reset:
// the entry memory is not reset, but the active flags are.
module weighted_pick_with_retirement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // entry_index[3:0], weight_in[19:4], limit_in[27:20],
	                               // random_word[59:28], zero[63:60]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // chosen_index[3:0], use_count[11:4], retired_now[12],
	                               // zero[15:13]
	output logic        m_tuser    // none_available[0]
);
	import wpr_pkg::*;

	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             res_ready;
	mem_req_t         mem_req;
	entry_t           mem_rdata;
	logic             scale_start;
	logic [31:0]      scale_rnd;
	logic [TOT_W-1:0] scale_total;
	logic [TOT_W-1:0] scale_thr;
	logic             scale_done;
	res_t             out_q;
	logic             out_valid_q;

	// unpack the request
	assign req.cmd    = s_tuser;
	assign req.idx    = s_tdata[3:0];
	assign req.weight = s_tdata[19:4];
	assign req.limit  = s_tdata[27:20];
	assign req.rnd    = s_tdata[59:28];

	wpr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_tvalid),
		.req_ready   (s_tready),
		.req         (req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata),
		.scale_start (scale_start),
		.scale_rnd   (scale_rnd),
		.scale_total (scale_total),
		.scale_thr   (scale_thr),
		.scale_done  (scale_done)
	);

	wpr_table u_table (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

	wpr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.rnd    (scale_rnd),
		.total  (scale_total),
		.thr    (scale_thr),
		.done   (scale_done)
	);

	// output register, refilled in the cycle it drains
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.retired, out_q.count, out_q.chosen};
	assign m_tuser  = out_q.none;

endmodule
